// File: rtl/sbus_frame_encoder_failsafe_defines.svh
// Assertion macros for the SBUS frame encoder.
// Included by the top level; relies on signals named clock and reset in the including scope.
`ifndef SBUS_FRAME_ENCODER_FAILSAFE_DEFINES_SVH
`define SBUS_FRAME_ENCODER_FAILSAFE_DEFINES_SVH
`ifndef SYNTH
// Condition implies consequence in the same cycle.
`define SFE_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Condition implies consequence in the next cycle.
`define SFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SFE_ASSERT_IMPLIES(label, ante, cons, msg)
`define SFE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/sfe_pkg.sv
// Shared types and constants for the SBUS frame encoder.
// No dependencies; used by every module of the block except sfe_fifo.
package sfe_pkg;

   // Item kinds
   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_PACKET = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] channel_0_us;
      logic [15:0] channel_1_us;
      logic [15:0] channel_2_us;
      logic [15:0] channel_3_us;
      logic [15:0] channel_4_us;
      logic [15:0] channel_5_us;
      logic [15:0] channel_6_us;
      logic [15:0] channel_7_us;
      logic [15:0] channel_8_us;
      logic [15:0] channel_9_us;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_INTERVAL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_TIMEOUT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAILSAFE_TIMEOUT = 2'd2;

   localparam logic [7:0]  RESET_FRAME_INTERVAL   = 8'd14;
   localparam logic [15:0] RESET_LOST_TIMEOUT     = 16'd28;
   localparam logic [15:0] RESET_FAILSAFE_TIMEOUT = 16'd500;

   // Channel storage
   localparam int RECEIVED_CHANNELS_DEFAULT = 10;
   localparam int NUM_IN_CHANNELS           = 10;
   localparam int THROTTLE_CHANNEL          = 2;
   localparam logic [15:0] RESET_PULSE_US    = 16'd1500;
   localparam logic [15:0] RESET_THROTTLE_US = 16'd1000;
   localparam logic [15:0] AGE_MAX           = 16'hFFFF;

   // SBUS frame
   localparam int BYTE_W            = 8;
   localparam int SBUS_NUM_CHANNELS = 16;
   localparam int SBUS_CHANNEL_W    = 11;
   localparam logic [7:0] FRAME_HEAD_BYTE = 8'h0F;
   localparam logic [7:0] FRAME_TAIL_BYTE = 8'h00;
   localparam logic [7:0] FLAG_FRAME_LOST = 8'h20;
   localparam logic [7:0] FLAG_FAILSAFE   = 8'h10;
   localparam logic [SBUS_CHANNEL_W-1:0] SBUS_MID = 11'd992;
   localparam logic [SBUS_CHANNEL_W-1:0] SBUS_MIN = 11'd172;
   localparam logic [SBUS_CHANNEL_W-1:0] SBUS_MAX = 11'd1811;

   // Pulse width to SBUS value scaling: (x - 1000) * 1639 / 1000 + 172
   localparam logic [15:0] PULSE_LOW_US  = 16'd1000;
   localparam logic [15:0] PULSE_HIGH_US = 16'd2000;
   localparam int DIFF_W      = 10;
   localparam int PRODUCT_W   = 21;
   localparam int MAP_SCALE   = 1639;
   localparam int MAP_DIVISOR = 1000;
   // The divide by 1000 is a multiply by ceil(2^31 / 1000) and a shift by 31. The
   // rounding error stays below one unit for every product under 2^21.
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 31;
   localparam logic [RECIP_W-1:0] MAP_RECIPROCAL = 22'd2147484;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_LOAD,
      BK_DIV,
      BK_PACK,
      BK_BYTE,
      BK_FLAGS,
      BK_END
   } back_state_type;

endpackage

// File: rtl/sbus_frame_encoder_failsafe.sv
// Top level of the SBUS frame encoder with frame-lost and failsafe flags.
// Depends on sfe_pkg, sfe_front, sfe_fifo, sfe_back and the assertion macro header.
//
// Input beats are either a one-millisecond tick or a packet of ten pulse widths in
// microseconds. A packet replaces the stored widths and clears the packet age. A tick
// ages the packet (saturating at 65535) and advances the frame timer; when the timer
// reaches frame_interval it restarts and one 25-byte SBUS frame leaves on the response
// channel, one byte per beat, with last_byte set on the closing 0x00. The frame holds
// the start byte 0x0F, sixteen 11-bit channels packed LSB first, and a flag byte with
// 0x20 (frame lost) and 0x10 (failsafe) set when the age, counted after the current
// tick, exceeds lost_timeout or failsafe_timeout. The front end takes one input beat
// per cycle as long as the two-entry frame queue has room; a tick that starts a frame
// captures the channel widths and flags at that moment, so later packets do not disturb
// a frame in flight. The back end maps every mapped channel whose width lies above 1000
// and at most 2000 us by multiplying it by 1639 in the load state and dividing by 1000
// with a reciprocal multiply in the divide state; other channels skip the divide state,
// and a stalled response side holds the back end. Register writes (index 0 frame
// interval, 1 lost timeout, 2 failsafe timeout; other indexes are ignored) are taken
// every cycle and should be made while the block is idle.
`include "sbus_frame_encoder_failsafe_defines.svh"

module sbus_frame_encoder_failsafe #(
   parameter int RECEIVED_CHANNELS = sfe_pkg::RECEIVED_CHANNELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sfe_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sfe_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfe_pkg::CSR_DATA_W-1:0]  csr_data
);

   import sfe_pkg::*;

   // Channels that packets actually write; the rest of the received channels keep
   // the reset width.
   localparam int STORED = (RECEIVED_CHANNELS < NUM_IN_CHANNELS) ?
                           RECEIVED_CHANNELS : NUM_IN_CHANNELS;
   // A frame command is the flag byte followed by a snapshot of the stored widths.
   localparam int CMD_W  = BYTE_W + 16 * STORED;

   logic             push_valid;
   logic             push_ready;
   logic [CMD_W-1:0] push_data;
   logic             pop_valid;
   logic             pop_ready;
   logic [CMD_W-1:0] pop_data;
   logic             back_idle;

   // Front end: input and register beats, channel store, age and frame timer.
   sfe_front #(
      .RECEIVED_CHANNELS(RECEIVED_CHANNELS),
      .CMD_W(CMD_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cmd_valid(push_valid),
      .cmd_ready(push_ready),
      .cmd_data(push_data)
   );

   // Frame command queue: lets ticks and packets keep flowing while a frame drains.
   sfe_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   // Back end: channel mapping, bit packing and the registered byte output.
   sfe_back #(
      .RECEIVED_CHANNELS(RECEIVED_CHANNELS),
      .CMD_W(CMD_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(pop_valid),
      .cmd_ready(pop_ready),
      .cmd_data(pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .back_idle(back_idle)
   );

   // A due frame is only issued when the queue can hold it.
   `SFE_ASSERT_IMPLIES(a_frame_cmd_has_room, push_valid, push_ready, "frame command lost")
   // Once the back end is idle, the only byte still waiting is a closing one.
   `SFE_ASSERT_IMPLIES(a_idle_holds_last, back_idle && rsp_valid, rsp_data.last_byte, "open frame")
   // Taking a command always starts a frame.
   `SFE_ASSERT_NEXT(a_cmd_starts_frame, pop_valid && pop_ready, !back_idle, "frame not started")

endmodule

// File: rtl/sfe_fifo.sv
// Small first-in first-out queue of frame commands between front and back.
// Depends on nothing but its parameters.
module sfe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/sfe_front.sv
// Front end: takes input beats and register writes, keeps channel store, age and frame timer.
// Depends on sfe_pkg; issues one frame command per frame into the queue.
module sfe_front #(
   parameter int RECEIVED_CHANNELS = sfe_pkg::RECEIVED_CHANNELS_DEFAULT,
   parameter int CMD_W             = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sfe_pkg::req_type                   req_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfe_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output logic [CMD_W-1:0]                   cmd_data
);

   import sfe_pkg::*;

   localparam int STORED = (RECEIVED_CHANNELS < NUM_IN_CHANNELS) ?
                           RECEIVED_CHANNELS : NUM_IN_CHANNELS;

   logic [NUM_IN_CHANNELS-1:0][15:0] ch_us;
   logic [STORED-1:0][15:0]          store_ff, store_in;
   logic [15:0]                      age_ff, age_in, age_step;
   logic [7:0]                       timer_ff, timer_in, timer_step;
   logic [7:0]                       interval_ff, interval_in;
   logic [15:0]                      lost_ff, lost_in;
   logic [15:0]                      failsafe_ff, failsafe_in;
   logic                             accept;
   logic                             fire;
   logic [7:0]                       flags;

   assign ch_us[0] = req_data.channel_0_us;
   assign ch_us[1] = req_data.channel_1_us;
   assign ch_us[2] = req_data.channel_2_us;
   assign ch_us[3] = req_data.channel_3_us;
   assign ch_us[4] = req_data.channel_4_us;
   assign ch_us[5] = req_data.channel_5_us;
   assign ch_us[6] = req_data.channel_6_us;
   assign ch_us[7] = req_data.channel_7_us;
   assign ch_us[8] = req_data.channel_8_us;
   assign ch_us[9] = req_data.channel_9_us;

   // Every input beat waits for queue room so a due frame is never dropped.
   assign req_ready  = cmd_ready;
   assign csr_ready  = 1'b1;
   assign accept     = req_valid && req_ready;

   assign age_step   = (age_ff == AGE_MAX) ? age_ff : age_ff + 16'd1;
   assign timer_step = timer_ff + 8'd1;
   assign fire       = (timer_step >= interval_ff);

   // Flags are judged on the age after this tick has been counted.
   assign flags = ((age_step > lost_ff)     ? FLAG_FRAME_LOST : 8'h00) |
                  ((age_step > failsafe_ff) ? FLAG_FAILSAFE   : 8'h00);

   assign cmd_valid = accept && (req_data.kind == KIND_TICK) && fire;
   assign cmd_data  = {flags, store_ff};

   always_comb begin
      store_in = store_ff;
      age_in   = age_ff;
      timer_in = timer_ff;
      if (accept) begin
         if (req_data.kind == KIND_PACKET) begin
            for (int i = 0; i < STORED; i++) begin
               store_in[i] = ch_us[i];
            end
            age_in = '0;
         end else begin
            age_in   = age_step;
            timer_in = fire ? 8'd0 : timer_step;
         end
      end
   end

   always_comb begin
      interval_in = interval_ff;
      lost_in     = lost_ff;
      failsafe_in = failsafe_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_INTERVAL: begin
               interval_in = csr_data[7:0];
            end
            CSR_LOST_TIMEOUT: begin
               lost_in = csr_data;
            end
            CSR_FAILSAFE_TIMEOUT: begin
               failsafe_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORED; i++) begin
            store_ff[i] <= (i == THROTTLE_CHANNEL) ? RESET_THROTTLE_US : RESET_PULSE_US;
         end
         age_ff      <= '0;
         timer_ff    <= '0;
         interval_ff <= RESET_FRAME_INTERVAL;
         lost_ff     <= RESET_LOST_TIMEOUT;
         failsafe_ff <= RESET_FAILSAFE_TIMEOUT;
      end else begin
         store_ff    <= store_in;
         age_ff      <= age_in;
         timer_ff    <= timer_in;
         interval_ff <= interval_in;
         lost_ff     <= lost_in;
         failsafe_ff <= failsafe_in;
      end
   end

endmodule

// File: rtl/sfe_back.sv
// Back end: turns one frame command into 25 SBUS bytes through a registered output stage.
// Depends on sfe_pkg; maps channels with a multiply by the scale and a reciprocal multiply.
module sfe_back #(
   parameter int RECEIVED_CHANNELS = sfe_pkg::RECEIVED_CHANNELS_DEFAULT,
   parameter int CMD_W             = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  logic [CMD_W-1:0] cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfe_pkg::rsp_type rsp_data,
   output logic             back_idle
);

   import sfe_pkg::*;

   localparam int STORED   = (RECEIVED_CHANNELS < NUM_IN_CHANNELS) ?
                             RECEIVED_CHANNELS : NUM_IN_CHANNELS;
   localparam int CH_IDX_W = $clog2(SBUS_NUM_CHANNELS);
   localparam int RC_W     = CH_IDX_W + 1;
   localparam int ACC_W    = SBUS_CHANNEL_W + BYTE_W - 1;
   localparam int NBITS_W  = $clog2(ACC_W + 1);
   localparam int RECIP_PROD_W = PRODUCT_W + RECIP_W;
   localparam logic [CH_IDX_W-1:0]     LAST_CH     = CH_IDX_W'(SBUS_NUM_CHANNELS - 1);
   localparam logic [RC_W-1:0]         RC_LIMIT    = RC_W'(RECEIVED_CHANNELS);
   localparam logic [PRODUCT_W-1:0]    SCALE_WIDE  = PRODUCT_W'(MAP_SCALE);
   localparam logic [RECIP_PROD_W-1:0] RECIP_WIDE  = RECIP_PROD_W'(MAP_RECIPROCAL);
   localparam logic [NBITS_W-1:0]      BYTE_BITS   = NBITS_W'(BYTE_W);
   localparam logic [NBITS_W-1:0]      CHAN_BITS   = NBITS_W'(SBUS_CHANNEL_W);

   back_state_type                     state_ff, state_in;
   logic [7:0]                         flags_ff, flags_in;
   logic [STORED-1:0][15:0]            chans_ff, chans_in;
   logic [CH_IDX_W-1:0]                chan_ff, chan_in;
   logic [SBUS_CHANNEL_W-1:0]          v_ff, v_in;
   logic [PRODUCT_W-1:0]               scaled_ff, scaled_in;
   logic [ACC_W-1:0]                   acc_ff, acc_in;
   logic [NBITS_W-1:0]                 nbits_ff, nbits_in;
   logic                               rsp_valid_ff;
   rsp_type                            rsp_data_ff;

   logic                               out_free;
   logic                               emit;
   rsp_type                            emit_data;
   logic                               chan_mapped;
   logic [15:0]                        x_us;
   logic [DIFF_W-1:0]                  diff;
   logic                               need_div;
   logic                               have_byte;
   logic [RECIP_PROD_W-1:0]            recip_product;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign back_idle = (state_ff == BK_IDLE);

   // Channel source: stored pulse width, the reset width for channels that packets
   // never carry, or no mapping at all above the received channel count.
   assign chan_mapped = ({1'b0, chan_ff} < RC_LIMIT);

   always_comb begin
      x_us = RESET_PULSE_US;
      for (int i = 0; i < STORED; i++) begin
         if (chan_ff == CH_IDX_W'(i)) begin
            x_us = chans_ff[i];
         end
      end
   end

   assign diff      = DIFF_W'(x_us - PULSE_LOW_US);
   assign need_div  = chan_mapped && (x_us > PULSE_LOW_US) && (x_us <= PULSE_HIGH_US);
   assign have_byte = (nbits_ff >= BYTE_BITS);
   // Quotient of the scaled width by 1000 sits above the reciprocal shift.
   assign recip_product = RECIP_PROD_W'(scaled_ff) * RECIP_WIDE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = BK_START;
            end
         end
         BK_START: begin
            if (out_free) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            state_in = need_div ? BK_DIV : BK_PACK;
         end
         BK_DIV: begin
            state_in = BK_PACK;
         end
         BK_PACK: begin
            state_in = BK_BYTE;
         end
         BK_BYTE: begin
            if (!have_byte) begin
               state_in = (chan_ff == LAST_CH) ? BK_FLAGS : BK_LOAD;
            end
         end
         BK_FLAGS: begin
            if (out_free) begin
               state_in = BK_END;
            end
         end
         BK_END: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      flags_in  = flags_ff;
      chans_in  = chans_ff;
      chan_in   = chan_ff;
      v_in      = v_ff;
      scaled_in = scaled_ff;
      acc_in    = acc_ff;
      nbits_in  = nbits_ff;
      cmd_ready = 1'b0;
      emit      = 1'b0;
      emit_data = '{frame_byte: FRAME_TAIL_BYTE, last_byte: 1'b0};
      unique case (state_ff)
         BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               flags_in = cmd_data[CMD_W-1 -: BYTE_W];
               chans_in = cmd_data[CMD_W-BYTE_W-1:0];
               chan_in  = '0;
               acc_in   = '0;
               nbits_in = '0;
            end
         end
         BK_START: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{frame_byte: FRAME_HEAD_BYTE, last_byte: 1'b0};
            end
         end
         BK_LOAD: begin
            if (!chan_mapped) begin
               v_in = SBUS_MID;
            end else if (x_us <= PULSE_LOW_US) begin
               v_in = SBUS_MIN;
            end else if (x_us > PULSE_HIGH_US) begin
               v_in = SBUS_MAX;
            end else begin
               scaled_in = PRODUCT_W'(diff) * SCALE_WIDE;
            end
         end
         BK_DIV: begin
            v_in = recip_product[RECIP_SHIFT +: SBUS_CHANNEL_W] + SBUS_MIN;
         end
         BK_PACK: begin
            acc_in   = acc_ff | (ACC_W'(v_ff) << nbits_ff);
            nbits_in = nbits_ff + CHAN_BITS;
         end
         BK_BYTE: begin
            if (have_byte) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_data = '{frame_byte: acc_ff[BYTE_W-1:0], last_byte: 1'b0};
                  acc_in    = acc_ff >> BYTE_W;
                  nbits_in  = nbits_ff - BYTE_BITS;
               end
            end else if (chan_ff != LAST_CH) begin
               chan_in = chan_ff + 1'b1;
            end
         end
         BK_FLAGS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{frame_byte: flags_ff, last_byte: 1'b0};
            end
         end
         BK_END: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{frame_byte: FRAME_TAIL_BYTE, last_byte: 1'b1};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      flags_ff  <= flags_in;
      chans_ff  <= chans_in;
      chan_ff   <= chan_in;
      v_ff      <= v_in;
      scaled_ff <= scaled_in;
      acc_ff    <= acc_in;
      nbits_ff  <= nbits_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

endmodule
